[hdl/mik_pkg.sv]
`default_nettype none

package mik_pkg;

    localparam int IN_W       = 16;              // vel_x, vel_y, yaw_rate
    localparam int CFG_W      = 16;              // inverse_radius, half_track_sum
    localparam int LIM_W      = 23;              // speed_limit
    localparam int OUT_W      = 24;              // wheel speeds, Q12.12
    localparam int NUM_WHEELS = 4;

    localparam int VEL_SHIFT  = 16;              // Q4.12 -> Q.28
    localparam int ROT_W      = 32;              // half_track_sum * yaw_rate
    localparam int SUM_W      = 34;              // signed Q.28 wheel sum
    localparam int MAG_W      = SUM_W - 1;       // magnitude of the sum
    localparam int RAD_SHIFT  = 24;              // Q.36 -> Q.12
    localparam int WMAG_W     = 25;              // unscaled wheel magnitude
    localparam int ACC_W      = WMAG_W + LIM_W;  // divider remainder/quotient word
    localparam int DIV_STEPS  = LIM_W;           // one quotient bit per stage

    localparam int STG_DIV0   = 7;               // first divider stage
    localparam int NUM_STG    = STG_DIV0 + DIV_STEPS + 1;

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int IN_TDATA_W = 3 * IN_W;
    localparam int OUT_TDATA_W = NUM_WHEELS * OUT_W;

    localparam int WHL_FL = 0;
    localparam int WHL_FR = 1;
    localparam int WHL_RL = 2;
    localparam int WHL_RR = 3;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_INV_RADIUS  = 2'd0;
    localparam t_reg_idx REG_HALF_TRACK  = 2'd1;
    localparam t_reg_idx REG_SPEED_LIMIT = 2'd2;

    typedef logic signed [OUT_W-1:0] t_wheel;

endpackage

`default_nettype wire

[hdl/mecanum_inverse_kinematics.sv]
// Throughput: one twist per cycle, fully pipelined, except while the spare output
// slot is full; the 23-stage scale divider (one quotient bit per stage, one per
// wheel) sets most of the latency.
// A two-entry output buffer keeps input acceptance going while one result waits.
// Reset (i_rst_n low, synchronous): all valid flags cleared, configuration registers to defaults.
`default_nettype none

module mecanum_inverse_kinematics (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // APB configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mik_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [mik_pkg::DATA_W-1:0]       pwdata,
    output logic      [mik_pkg::DATA_W-1:0]       prdata,
    output logic                                  pready,
    // twist in
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // vel_x, vel_y, yaw_rate
    input  wire logic [mik_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // wheel speeds out
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // wheel_front_left, wheel_front_right, wheel_rear_left, wheel_rear_right
    output logic [mik_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // was_scaled
    output logic [0:0]                            o_m_axis_tuser
);
    import mik_pkg::*;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_inv_radius;
    logic [CFG_W-1:0] r_half_track;
    logic [LIM_W-1:0] r_speed_limit;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_radius  <= CFG_W'(1280);
            r_half_track  <= CFG_W'(16384);
            r_speed_limit <= LIM_W'(1638400);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INV_RADIUS:  r_inv_radius  <= pwdata[CFG_W-1:0];
                REG_HALF_TRACK:  r_half_track  <= pwdata[CFG_W-1:0];
                REG_SPEED_LIMIT: r_speed_limit <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_INV_RADIUS:  prdata = DATA_W'(r_inv_radius);
            REG_HALF_TRACK:  prdata = DATA_W'(r_half_track);
            REG_SPEED_LIMIT: prdata = DATA_W'(r_speed_limit);
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic [NUM_STG-1:0] r_vld;
    logic               r_out_vld;
    logic               r_spare_vld;
    logic               n_out_vld;
    logic               n_spare_vld;
    logic               pipe_en;
    logic               push;
    logic               take;
    logic               out_from_pipe;
    logic               out_from_spare;
    logic               spare_load;

    // the pipeline only freezes once the spare output slot is taken
    assign pipe_en         = !r_spare_vld;
    assign o_s_axis_tready = pipe_en;
    assign push            = pipe_en & r_vld[NUM_STG-1];
    assign take            = r_out_vld & i_m_axis_tready;

    always_comb begin
        n_out_vld      = r_out_vld;
        n_spare_vld    = r_spare_vld;
        out_from_pipe  = 1'b0;
        out_from_spare = 1'b0;
        spare_load     = 1'b0;
        if (r_spare_vld) begin
            if (take) begin
                out_from_spare = 1'b1;
                n_spare_vld    = 1'b0;
            end
        end else if (push) begin
            if (!r_out_vld || take) begin
                out_from_pipe = 1'b1;
                n_out_vld     = 1'b1;
            end else begin
                spare_load  = 1'b1;
                n_spare_vld = 1'b1;
            end
        end else if (take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_vld   <= 1'b0;
            r_spare_vld <= 1'b0;
        end else begin
            if (pipe_en) begin
                r_vld <= {r_vld[NUM_STG-2:0], i_s_axis_tvalid};
            end
            r_out_vld   <= n_out_vld;
            r_spare_vld <= n_spare_vld;
        end
    end

    // ---------------- datapath ----------------
    // stage 0: twist capture
    logic signed [IN_W-1:0]  r_s0_vx;
    logic signed [IN_W-1:0]  r_s0_vy;
    logic signed [IN_W-1:0]  r_s0_yaw;
    // stage 1: rotation term
    logic signed [IN_W-1:0]  r_s1_vx;
    logic signed [IN_W-1:0]  r_s1_vy;
    logic signed [ROT_W-1:0] r_s1_rot;
    // stage 2: wheel sums, Q.28
    logic signed [SUM_W-1:0] r_s2_sum [NUM_WHEELS];
    // stage 3: sign and magnitude
    logic [MAG_W-1:0]        r_s3_mag [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   r_s3_neg;
    // stage 4: times inverse radius, truncated
    logic [WMAG_W-1:0]       r_s4_wmag [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   r_s4_neg;
    // stage 5: pairwise max
    logic [WMAG_W-1:0]       r_s5_wmag [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   r_s5_neg;
    logic [WMAG_W-1:0]       r_s5_max01;
    logic [WMAG_W-1:0]       r_s5_max23;
    // stage 6: overall max and limit check
    logic [WMAG_W-1:0]       r_s6_wmag [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   r_s6_neg;
    logic [WMAG_W-1:0]       r_s6_max;
    logic                    r_s6_over;
    // divider stages: index 0 holds the dividend, each later one adds a quotient bit
    logic [ACC_W-1:0]        r_div_acc [DIV_STEPS+1][NUM_WHEELS];
    logic [WMAG_W-1:0]       r_div_den [DIV_STEPS+1];
    logic [NUM_WHEELS-1:0]   r_div_neg [DIV_STEPS+1];
    logic                    r_div_ovr [DIV_STEPS+1];

    logic signed [CFG_W:0]      half_track_s;
    logic signed [CFG_W+IN_W:0] rot_full;
    logic signed [SUM_W-1:0]    vx28;
    logic signed [SUM_W-1:0]    vy28;
    logic signed [SUM_W-1:0]    rot28;
    logic [MAG_W+CFG_W-1:0]     wprod [NUM_WHEELS];
    logic [ACC_W-1:0]           n_num [NUM_WHEELS];
    logic [WMAG_W-1:0]          n_den;

    assign half_track_s = {1'b0, r_half_track};
    assign rot_full     = half_track_s * r_s0_yaw;
    assign vx28  = {{(SUM_W-IN_W-VEL_SHIFT){r_s1_vx[IN_W-1]}}, r_s1_vx, VEL_SHIFT'(0)};
    assign vy28  = {{(SUM_W-IN_W-VEL_SHIFT){r_s1_vy[IN_W-1]}}, r_s1_vy, VEL_SHIFT'(0)};
    assign rot28 = {{(SUM_W-ROT_W){r_s1_rot[ROT_W-1]}}, r_s1_rot};

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            wprod[i] = (MAG_W+CFG_W)'(r_s3_mag[i]) * (MAG_W+CFG_W)'(r_inv_radius);
            // without scaling the magnitude is within the limit, so it fits the
            // quotient field and a divide by one passes it through
            if (r_s6_over) begin
                n_num[i] = ACC_W'(r_s6_wmag[i]) * ACC_W'(r_speed_limit);
            end else begin
                n_num[i] = ACC_W'(r_s6_wmag[i]);
            end
        end
        n_den = r_s6_over ? r_s6_max : WMAG_W'(1);
    end

    // one restoring step: remainder in the upper bits, quotient shifts in below
    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                  input logic [WMAG_W-1:0] den);
        logic [WMAG_W:0] trial;
        logic [WMAG_W:0] diff;
        logic            ge;
        trial = acc[ACC_W-1 -: WMAG_W+1];
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});
        return {(ge ? diff[WMAG_W-1:0] : trial[WMAG_W-1:0]), acc[LIM_W-2:0], ge};
    endfunction

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s0_vx  <= i_s_axis_tdata[0 +: IN_W];
            r_s0_vy  <= i_s_axis_tdata[IN_W +: IN_W];
            r_s0_yaw <= i_s_axis_tdata[2*IN_W +: IN_W];

            r_s1_vx  <= r_s0_vx;
            r_s1_vy  <= r_s0_vy;
            r_s1_rot <= rot_full[ROT_W-1:0];

            r_s2_sum[WHL_FL] <=  vx28 - vy28 - rot28;
            r_s2_sum[WHL_FR] <= -vx28 - vy28 + rot28;
            r_s2_sum[WHL_RL] <= -vx28 - vy28 - rot28;
            r_s2_sum[WHL_RR] <=  vx28 - vy28 + rot28;

            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_s3_neg[i] <= r_s2_sum[i][SUM_W-1];
                r_s3_mag[i] <= r_s2_sum[i][SUM_W-1] ? MAG_W'(-r_s2_sum[i])
                                                    : MAG_W'(r_s2_sum[i]);

                r_s4_wmag[i] <= wprod[i][RAD_SHIFT +: WMAG_W];
                r_s5_wmag[i] <= r_s4_wmag[i];
                r_s6_wmag[i] <= r_s5_wmag[i];
                r_div_acc[0][i] <= n_num[i];
            end
            r_s4_neg <= r_s3_neg;
            r_s5_neg <= r_s4_neg;
            r_s6_neg <= r_s5_neg;

            r_s5_max01 <= (r_s4_wmag[WHL_FL] > r_s4_wmag[WHL_FR]) ? r_s4_wmag[WHL_FL]
                                                                   : r_s4_wmag[WHL_FR];
            r_s5_max23 <= (r_s4_wmag[WHL_RL] > r_s4_wmag[WHL_RR]) ? r_s4_wmag[WHL_RL]
                                                                   : r_s4_wmag[WHL_RR];

            r_s6_max  <= (r_s5_max01 > r_s5_max23) ? r_s5_max01 : r_s5_max23;
            r_s6_over <= (r_s5_max01 > WMAG_W'(r_speed_limit))
                      || (r_s5_max23 > WMAG_W'(r_speed_limit));

            r_div_den[0] <= n_den;
            r_div_neg[0] <= r_s6_neg;
            r_div_ovr[0] <= r_s6_over;

            for (int k = 1; k <= DIV_STEPS; k++) begin
                for (int i = 0; i < NUM_WHEELS; i++) begin
                    r_div_acc[k][i] <= div_step(r_div_acc[k-1][i], r_div_den[k-1]);
                end
                r_div_den[k] <= r_div_den[k-1];
                r_div_neg[k] <= r_div_neg[k-1];
                r_div_ovr[k] <= r_div_ovr[k-1];
            end
        end
    end

    // ---------------- output buffer ----------------
    t_wheel n_fin_wheel [NUM_WHEELS];
    t_wheel r_out_wheel [NUM_WHEELS];
    t_wheel r_spare_wheel [NUM_WHEELS];
    logic   r_out_scaled;
    logic   r_spare_scaled;

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            if (r_div_neg[DIV_STEPS][i]) begin
                n_fin_wheel[i] = -OUT_W'(r_div_acc[DIV_STEPS][i][LIM_W-1:0]);
            end else begin
                n_fin_wheel[i] = OUT_W'(r_div_acc[DIV_STEPS][i][LIM_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_from_pipe) begin
            r_out_wheel  <= n_fin_wheel;
            r_out_scaled <= r_div_ovr[DIV_STEPS];
        end else if (out_from_spare) begin
            r_out_wheel  <= r_spare_wheel;
            r_out_scaled <= r_spare_scaled;
        end
        if (spare_load) begin
            r_spare_wheel  <= n_fin_wheel;
            r_spare_scaled <= r_div_ovr[DIV_STEPS];
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = {r_out_wheel[WHL_RR], r_out_wheel[WHL_RL],
                                r_out_wheel[WHL_FR], r_out_wheel[WHL_FL]};
    assign o_m_axis_tuser[0] = r_out_scaled;

    // ---------------- assertions ----------------
    logic [OUT_W-1:0] chk_mag [NUM_WHEELS];

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            chk_mag[i] = r_out_wheel[i][OUT_W-1] ? OUT_W'(-r_out_wheel[i])
                                                 : OUT_W'(r_out_wheel[i]);
        end
    end

    a_spare_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare_vld |-> r_out_vld)
        else $error("spare slot holds a result while the output slot is empty");

    a_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (chk_mag[WHL_FL] <= OUT_W'(r_speed_limit))
                         && (chk_mag[WHL_FR] <= OUT_W'(r_speed_limit))
                         && (chk_mag[WHL_RL] <= OUT_W'(r_speed_limit))
                         && (chk_mag[WHL_RR] <= OUT_W'(r_speed_limit)))
        else $error("wheel speed above the configured limit");

    a_zero_radius_unscaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_inv_radius == '0)) |-> !o_m_axis_tuser[0])
        else $error("scaling flagged with zero inverse radius");

endmodule

`default_nettype wire
